// ----- hdl/usbe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbe_pkg
// Types, code constants and sizes shared by the stego bit extractor files.
// ----------------------------------------------------------------------------
package usbe_pkg;

    localparam int MAP_DEPTH  = 16;
    localparam int CP_W       = 21;
    localparam int EIDX_W     = 4;
    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int ENTRIES_W  = 5;
    localparam int IDX_RAW_W  = $clog2(MAP_DEPTH + 1);
    localparam int CMP_W      = (IDX_RAW_W > ENTRIES_W) ? IDX_RAW_W : ENTRIES_W;

    typedef logic [CP_W-1:0]    t_cp;
    typedef logic [EIDX_W-1:0]  t_eidx;
    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [CMP_W-1:0]   t_cell_idx;

    typedef enum logic [2:0] {
        MODE_TAGS      = 3'd0,
        MODE_ZW        = 3'd1,
        MODE_NIBBLES   = 3'd2,
        MODE_MONGOLIAN = 3'd3,
        MODE_BIDI      = 3'd4,
        MODE_MAP       = 3'd5,
        MODE_PAIRS     = 3'd6
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DECODE_MODE   = 2'd0,
        REG_LSB_FIRST     = 2'd1,
        REG_MAP_BIT_WIDTH = 2'd2,
        REG_MAP_ENTRIES   = 2'd3
    } t_reg_idx;

    localparam t_cp CP_TAG_BEGIN   = 21'h0E0001;
    localparam t_cp CP_TAG_CANCEL  = 21'h0E007F;
    localparam t_cp CP_TAG_LO      = 21'h0E0020;
    localparam t_cp CP_TAG_HI      = 21'h0E007E;
    localparam t_cp CP_ZWSP        = 21'h00200B;
    localparam t_cp CP_ZWNJ        = 21'h00200C;
    localparam t_cp CP_VS_LO       = 21'h00FE00;
    localparam t_cp CP_VS_HI       = 21'h00FE0F;
    localparam t_cp CP_MONGOLIAN_A = 21'h001820;
    localparam t_cp CP_FVS1        = 21'h00180B;
    localparam t_cp CP_FVS2        = 21'h00180C;
    localparam t_cp CP_LRI         = 21'h002066;
    localparam t_cp CP_RLI         = 21'h002067;
    localparam t_cp CP_IDEO_COMMA  = 21'h003001;
    localparam t_cp CP_ITER_MARK   = 21'h003005;

    localparam t_count CNT_ONE    = 4'd1;
    localparam t_count CNT_NIBBLE = 4'd4;
    localparam t_count CNT_BYTE   = 4'd8;

    typedef struct packed {
        logic   hit;
        t_byte  bits;
        t_count cnt;
        logic   map_req;
    } t_front_res;

    typedef struct packed {
        logic   is_load;
        t_cp    cp;
        t_eidx  entry_idx;
        t_cp    entry_cp;
        t_byte  entry_val;
        logic   hit;
        t_byte  bits;
        t_count cnt;
        logic   map_req;
        logic   found;
    } t_token;

endpackage

// ----- hdl/usbe_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbe_in_if
// Input channel: one decode or alphabet load item per transfer.
// ----------------------------------------------------------------------------
interface usbe_in_if import usbe_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  opcode;
    t_cp   code_point;
    t_eidx entry_index;
    t_cp   entry_codepoint;
    t_byte entry_value;

    modport source (
        output valid, opcode, code_point, entry_index, entry_codepoint, entry_value,
        input  ready
    );
    modport sink (
        input  valid, opcode, code_point, entry_index, entry_codepoint, entry_value,
        output ready
    );
endinterface

// ----- hdl/usbe_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbe_out_if
// Output channel: one group of extracted bits per transfer.
// ----------------------------------------------------------------------------
interface usbe_out_if import usbe_pkg::*; ();
    logic   valid;
    logic   ready;
    t_byte  out_bits;
    t_count bit_count;

    modport source (output valid, out_bits, bit_count, input ready);
    modport sink (input valid, out_bits, bit_count, output ready);
endinterface

// ----- hdl/unicode_stego_bit_extractor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unicode_stego_bit_extractor
// Extracts hidden bits from a stream of Unicode code points.
// ----------------------------------------------------------------------------
// Items arrive on i_in: opcode 0 decodes code_point in the mode held in the
// decode_mode register, opcode 1 loads one alphabet slot. Each decode item
// yields zero or one transfer on o_out carrying 1 to 8 bits, first bit in
// the most significant used position. Registers are written through the
// i_cfg_* port; the user must write them only while the block is idle, as
// the block itself does not enforce it. Every item walks a row of MAP_DEPTH
// slot cells, each a register, and then the output register. The row is a
// pipeline: one item is taken per cycle as long as results are taken.
// The whole row moves together, so while o_out holds a result that the
// receiver does not take, i_in.ready is low and nothing moves.
// Reset empties the row and the output register, clears the tracking state
// and restores the register defaults; alphabet slots hold no defined value
// until loaded.
// ----------------------------------------------------------------------------
module unicode_stego_bit_extractor import usbe_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    usbe_in_if.sink               i_in,
    usbe_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_mode                r_mode;
    logic                 r_lsb_first;
    t_count               r_width;
    logic [ENTRIES_W-1:0] r_entries;

    logic       w_adv;
    logic       w_take;
    t_front_res w_front;
    logic       w_vld [MAP_DEPTH+1];
    t_token     w_tok [MAP_DEPTH+1];

    t_count w_w;
    t_byte  w_masked;
    t_byte  w_rev;
    t_byte  n_bits;
    t_count n_cnt;
    logic   n_out_valid;
    logic   r_out_valid;
    t_byte  r_out_bits;
    t_count r_out_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_TAGS;
            r_lsb_first <= 1'b0;
            r_width     <= CNT_BYTE;
            r_entries   <= ENTRIES_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_DECODE_MODE:   r_mode      <= t_mode'(i_cfg_wdata[2:0]);
                REG_LSB_FIRST:     r_lsb_first <= i_cfg_wdata[0];
                REG_MAP_BIT_WIDTH: r_width     <= i_cfg_wdata[COUNT_W-1:0];
                REG_MAP_ENTRIES:   r_entries   <= i_cfg_wdata[ENTRIES_W-1:0];
            endcase
        end
    end

    assign w_adv      = !r_out_valid || o_out.ready;
    assign i_in.ready = w_adv;
    assign w_take     = i_in.valid && w_adv && !i_in.opcode;

    usbe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_mode  (r_mode),
        .i_cp    (i_in.code_point),
        .o_res   (w_front)
    );

    assign w_vld[0] = i_in.valid;
    assign w_tok[0] = '{
        is_load:   i_in.opcode,
        cp:        i_in.code_point,
        entry_idx: i_in.entry_index,
        entry_cp:  i_in.entry_codepoint,
        entry_val: i_in.entry_value,
        hit:       w_front.hit && !i_in.opcode,
        bits:      w_front.bits,
        cnt:       w_front.cnt,
        map_req:   w_front.map_req && !i_in.opcode,
        found:     1'b0
    };

    for (genvar g = 0; g < MAP_DEPTH; g++) begin : g_cell
        usbe_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_adv       (w_adv),
            .i_index     (CMP_W'(g)),
            .i_search_en (CMP_W'(g) < CMP_W'(r_entries)),
            .i_valid     (w_vld[g]),
            .i_tok       (w_tok[g]),
            .o_valid     (w_vld[g+1]),
            .o_tok       (w_tok[g+1])
        );
    end

    assign w_w = (r_width == '0) ? CNT_ONE : ((r_width > CNT_BYTE) ? CNT_BYTE : r_width);

    always_comb begin
        logic [COUNT_W-1:0] k;
        for (int j = 0; j < BYTE_W; j++) begin
            w_masked[j] = w_tok[MAP_DEPTH].bits[j] && (COUNT_W'(j) < w_w);
        end
        for (int j = 0; j < BYTE_W; j++) begin
            k        = w_w - CNT_ONE - COUNT_W'(j);
            w_rev[j] = (COUNT_W'(j) < w_w) ? w_masked[k[2:0]] : 1'b0;
        end
    end

    always_comb begin
        n_out_valid = w_vld[MAP_DEPTH] && (w_tok[MAP_DEPTH].hit || w_tok[MAP_DEPTH].found);
        if (w_tok[MAP_DEPTH].found) begin
            n_bits = r_lsb_first ? w_rev : w_masked;
            n_cnt  = w_w;
        end else begin
            n_bits = w_tok[MAP_DEPTH].bits;
            n_cnt  = w_tok[MAP_DEPTH].cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_bits <= n_bits;
            r_out_cnt  <= n_cnt;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_bits  = r_out_bits;
    assign o_out.bit_count = r_out_cnt;

endmodule

// ----- hdl/usbe_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbe_front
// Fixed-mode decoder with the tag-run, Mongolian and pair tracking state.
// ----------------------------------------------------------------------------
module usbe_front import usbe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  t_mode      i_mode,
    input  t_cp        i_cp,
    output t_front_res o_res
);

    logic r_in_tag_run;
    logic n_in_tag_run;
    logic r_prev_a;
    logic n_prev_a;
    t_cp  r_pair_first;
    t_cp  n_pair_first;
    logic r_pair_have;
    logic n_pair_have;

    always_comb begin
        o_res        = '0;
        n_in_tag_run = r_in_tag_run;
        n_prev_a     = (i_cp == CP_MONGOLIAN_A);
        n_pair_first = r_pair_first;
        n_pair_have  = r_pair_have;
        unique case (i_mode)
            MODE_TAGS: begin
                if (i_cp == CP_TAG_BEGIN) begin
                    n_in_tag_run = 1'b1;
                end else if (i_cp == CP_TAG_CANCEL) begin
                    n_in_tag_run = 1'b0;
                end else if (r_in_tag_run && i_cp >= CP_TAG_LO && i_cp <= CP_TAG_HI) begin
                    o_res.hit  = 1'b1;
                    o_res.bits = i_cp[BYTE_W-1:0];
                    o_res.cnt  = CNT_BYTE;
                end
            end
            MODE_ZW: begin
                if (i_cp == CP_ZWSP || i_cp == CP_ZWNJ) begin
                    o_res.hit  = 1'b1;
                    o_res.bits = {{(BYTE_W-1){1'b0}}, i_cp == CP_ZWNJ};
                    o_res.cnt  = CNT_ONE;
                end
            end
            MODE_NIBBLES: begin
                if (i_cp >= CP_VS_LO && i_cp <= CP_VS_HI) begin
                    o_res.hit  = 1'b1;
                    o_res.bits = {4'd0, i_cp[3:0]};
                    o_res.cnt  = CNT_NIBBLE;
                end
            end
            MODE_MONGOLIAN: begin
                if (r_prev_a && (i_cp == CP_FVS1 || i_cp == CP_FVS2)) begin
                    o_res.hit  = 1'b1;
                    o_res.bits = {{(BYTE_W-1){1'b0}}, i_cp == CP_FVS2};
                    o_res.cnt  = CNT_ONE;
                end
            end
            MODE_BIDI: begin
                if (i_cp == CP_LRI || i_cp == CP_RLI) begin
                    o_res.hit  = 1'b1;
                    o_res.bits = {{(BYTE_W-1){1'b0}}, i_cp == CP_RLI};
                    o_res.cnt  = CNT_ONE;
                end
            end
            MODE_MAP: begin
                o_res.map_req = 1'b1;
            end
            MODE_PAIRS: begin
                if (i_cp == CP_IDEO_COMMA) begin
                    n_pair_have = 1'b0;
                end else if (!r_pair_have) begin
                    n_pair_first = i_cp;
                    n_pair_have  = 1'b1;
                end else begin
                    if (i_cp == r_pair_first) begin
                        o_res.hit = 1'b1;
                        o_res.cnt = CNT_ONE;
                    end else if (i_cp == CP_ITER_MARK) begin
                        o_res.hit  = 1'b1;
                        o_res.bits = {{(BYTE_W-1){1'b0}}, 1'b1};
                        o_res.cnt  = CNT_ONE;
                    end
                    n_pair_have = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_tag_run <= 1'b0;
            r_prev_a     <= 1'b0;
            r_pair_first <= '0;
            r_pair_have  <= 1'b0;
        end else if (i_take) begin
            r_in_tag_run <= n_in_tag_run;
            r_prev_a     <= n_prev_a;
            r_pair_first <= n_pair_first;
            r_pair_have  <= n_pair_have;
        end
    end

endmodule

// ----- hdl/usbe_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbe_cell
// One alphabet slot: stores a code point and value, loads and matches
// the item passing through, and hands it to the next slot.
// ----------------------------------------------------------------------------
module usbe_cell import usbe_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_adv,
    input  t_cell_idx i_index,
    input  logic      i_search_en,
    input  logic      i_valid,
    input  t_token    i_tok,
    output logic      o_valid,
    output t_token    o_tok
);

    t_cp    r_cp;
    t_byte  r_val;
    logic   r_valid;
    t_token r_tok;
    t_token n_tok;
    logic   w_sel;

    assign w_sel = (CMP_W'(i_tok.entry_idx) == i_index);

    always_comb begin
        n_tok = i_tok;
        if (!i_tok.is_load && i_tok.map_req && !i_tok.found && i_search_en
                && r_cp == i_tok.cp) begin
            n_tok.found = 1'b1;
            n_tok.bits  = r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid && i_tok.is_load && w_sel) begin
            r_cp  <= i_tok.entry_cp;
            r_val <= i_tok.entry_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;

endmodule

// ----- hdl/usbe_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbe_checker
// Port-level checks of the stego bit extractor, bound to the top level.
// ----------------------------------------------------------------------------
module usbe_checker import usbe_pkg::*; (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_in_valid,
    input logic   i_in_ready,
    input logic   i_out_valid,
    input logic   i_out_ready,
    input t_byte  i_out_bits,
    input t_count i_bit_count
);

    a_count_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_bit_count >= CNT_ONE && i_bit_count <= CNT_BYTE))
        else $error("bit count out of range");

    a_upper_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_out_bits >> i_bit_count) == '0))
        else $error("bits above the count are set");

    a_ready_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("input stalled without an output stall");

    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_bits)
            && $stable(i_bit_count)))
        else $error("stalled result changed");

endmodule

bind unicode_stego_bit_extractor usbe_checker u_usbe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_bits  (o_out.out_bits),
    .i_bit_count (o_out.bit_count)
);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for unicode_stego_bit_extractor.
// Decode and alphabet load items go in with random gaps, and the output side
// stalls at random. Every accepted item runs through a local model of the
// extractor. Each output transfer is checked in order against the oldest
// predicted bit group. The run walks through every decode mode and many
// register settings, the out-of-range ones among them.
// ----------------------------------------------------------------------------
module tb;
    import usbe_pkg::*;

    localparam logic       OP_DECODE     = 1'b0;
    localparam logic       OP_LOAD       = 1'b1;
    localparam t_cp        TAG_BASE      = 21'h0E0000;
    localparam t_cp        CP_MAX        = 21'h10FFFF;
    localparam int         N_PHASES      = 32;
    localparam int         PHASE_ITEMS   = 20;
    localparam int         CALM_PHASES   = 4;
    localparam int         SETTLE_CYCLES = 2 * MAP_DEPTH + 4;
    localparam int         CYCLE_LIMIT   = 500000;

    typedef struct packed {
        logic  opcode;
        t_cp   cp;
        t_eidx idx;
        t_cp   ecp;
        t_byte eval;
    } t_item;

    typedef struct packed {
        t_byte  bits;
        t_count cnt;
    } t_bits;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    usbe_in_if  in_ch ();
    usbe_out_if out_ch ();

    unicode_stego_bit_extractor u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    t_item item_q[$];
    t_bits bits_q[$];

    // Local copy of the extractor state and registers.
    logic [2:0] cfg_mode;
    logic       cfg_lsb_first;
    logic [3:0] cfg_width;
    logic [4:0] cfg_entries;
    logic       tag_run;
    logic       prev_mongolian_a;
    t_cp        pair_cp;
    logic       pair_open;
    t_cp        slot_cp [MAP_DEPTH];
    t_byte      slot_val [MAP_DEPTH];

    t_cp         gen_slot_cp [MAP_DEPTH];
    int unsigned gen_count;
    int unsigned n_err;
    int unsigned cycles;
    int unsigned in_gap;
    int unsigned out_stall;
    bit          in_fired;
    bit          idle_on;
    t_item       taken_item;
    t_bits       want;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic extract_hidden_bits(input t_item it);
        logic        prev_a;
        logic        hit;
        t_byte       val;
        t_count      cnt;
        t_cp         d;
        int unsigned w;
        int unsigned n;
        int unsigned i;
        t_byte       v;
        t_byte       r;
        begin
            hit = 1'b0;
            val = '0;
            cnt = '0;
            if (it.opcode == OP_LOAD) begin
                slot_cp[it.idx]  = it.ecp;
                slot_val[it.idx] = it.eval;
            end else begin
                prev_a = prev_mongolian_a;
                prev_mongolian_a = (it.cp == CP_MONGOLIAN_A);
                case (cfg_mode)
                    MODE_TAGS: begin
                        if (it.cp == CP_TAG_BEGIN) begin
                            tag_run = 1'b1;
                        end else if (it.cp == CP_TAG_CANCEL) begin
                            tag_run = 1'b0;
                        end else if (tag_run && it.cp >= CP_TAG_LO && it.cp <= CP_TAG_HI) begin
                            d = it.cp - TAG_BASE;
                            hit = 1'b1;
                            val = d[7:0];
                            cnt = CNT_BYTE;
                        end
                    end
                    MODE_ZW: begin
                        if (it.cp == CP_ZWSP || it.cp == CP_ZWNJ) begin
                            hit = 1'b1;
                            val = (it.cp == CP_ZWNJ) ? 8'd1 : 8'd0;
                            cnt = CNT_ONE;
                        end
                    end
                    MODE_NIBBLES: begin
                        if (it.cp >= CP_VS_LO && it.cp <= CP_VS_HI) begin
                            d = it.cp - CP_VS_LO;
                            hit = 1'b1;
                            val = d[7:0];
                            cnt = CNT_NIBBLE;
                        end
                    end
                    MODE_MONGOLIAN: begin
                        if (prev_a && (it.cp == CP_FVS1 || it.cp == CP_FVS2)) begin
                            hit = 1'b1;
                            val = (it.cp == CP_FVS2) ? 8'd1 : 8'd0;
                            cnt = CNT_ONE;
                        end
                    end
                    MODE_BIDI: begin
                        if (it.cp == CP_LRI || it.cp == CP_RLI) begin
                            hit = 1'b1;
                            val = (it.cp == CP_RLI) ? 8'd1 : 8'd0;
                            cnt = CNT_ONE;
                        end
                    end
                    MODE_MAP: begin
                        w = (cfg_width == 0) ? 1 : ((cfg_width > 8) ? 8 : cfg_width);
                        n = (cfg_entries > MAP_DEPTH) ? MAP_DEPTH : cfg_entries;
                        for (i = 0; i < n; i++) begin
                            if (!hit && slot_cp[t_eidx'(i)] == it.cp) begin
                                v = slot_val[t_eidx'(i)] & t_byte'((1 << w) - 1);
                                if (cfg_lsb_first) begin
                                    r = '0;
                                    for (int j = 0; j < w; j++) r = {r[BYTE_W-2:0], v[j]};
                                    v = r;
                                end
                                hit = 1'b1;
                                val = v;
                                cnt = t_count'(w);
                            end
                        end
                    end
                    MODE_PAIRS: begin
                        if (it.cp == CP_IDEO_COMMA) begin
                            pair_open = 1'b0;
                        end else if (!pair_open) begin
                            pair_cp   = it.cp;
                            pair_open = 1'b1;
                        end else begin
                            if (it.cp == pair_cp) begin
                                hit = 1'b1;
                                val = 8'd0;
                                cnt = CNT_ONE;
                            end else if (it.cp == CP_ITER_MARK) begin
                                hit = 1'b1;
                                val = 8'd1;
                                cnt = CNT_ONE;
                            end
                            pair_open = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
                if (hit) bits_q.push_back('{bits: val, cnt: cnt});
            end
        end
    endtask

    function automatic t_cp special_cp(input int unsigned k);
        case (k)
            0:       return CP_TAG_BEGIN;
            1:       return CP_TAG_CANCEL;
            2:       return CP_TAG_LO;
            3:       return CP_TAG_HI;
            4:       return CP_ZWSP;
            5:       return CP_ZWNJ;
            6:       return CP_VS_LO;
            7:       return CP_VS_HI;
            8:       return CP_MONGOLIAN_A;
            9:       return CP_FVS1;
            10:      return CP_FVS2;
            11:      return CP_LRI;
            12:      return CP_RLI;
            13:      return CP_IDEO_COMMA;
            default: return CP_ITER_MARK;
        endcase
    endfunction

    function automatic t_cp rand_cp();
        t_cp c;
        begin
            case ($urandom_range(0, 3))
                0:       c = t_cp'($urandom_range(0, CP_MAX));
                1:       c = t_cp'($urandom_range(0, 16'hFFFF));
                2:       c = special_cp($urandom_range(0, 14));
                default: c = t_cp'(special_cp($urandom_range(0, 14))
                                   + $urandom_range(0, 2) - 1);
            endcase
            return c;
        end
    endfunction

    task automatic push_decode(input t_cp cp);
        t_item it;
        begin
            it.opcode = OP_DECODE;
            it.cp     = cp;
            it.idx    = t_eidx'($urandom);
            it.ecp    = t_cp'($urandom_range(0, CP_MAX));
            it.eval   = t_byte'($urandom);
            item_q.push_back(it);
            gen_count++;
        end
    endtask

    task automatic push_load(input t_eidx idx, input t_cp ecp, input t_byte eval);
        t_item it;
        begin
            it.opcode = OP_LOAD;
            it.cp     = t_cp'($urandom_range(0, CP_MAX));
            it.idx    = idx;
            it.ecp    = ecp;
            it.eval   = eval;
            gen_slot_cp[idx] = ecp;
            item_q.push_back(it);
            gen_count++;
        end
    endtask

    task automatic push_random_load();
        t_eidx k;
        begin
            k = t_eidx'($urandom_range(0, MAP_DEPTH - 1));
            // Half of the loads copy another slot so that duplicates occur.
            push_load(t_eidx'($urandom_range(0, MAP_DEPTH - 1)),
                      $urandom_range(0, 1) ? gen_slot_cp[k] : rand_cp(),
                      t_byte'($urandom_range(0, 255)));
        end
    endtask

    task automatic push_burst(input logic [2:0] mode);
        t_cp         x;
        int unsigned n;
        begin
            x = rand_cp();
            case (mode)
                MODE_TAGS: begin
                    if ($urandom_range(0, 4) != 0) push_decode(CP_TAG_BEGIN);
                    n = $urandom_range(1, 6);
                    repeat (n) begin
                        case ($urandom_range(0, 7))
                            0:       push_decode(TAG_BASE + t_cp'($urandom_range(0, 8'h1F)));
                            1:       push_decode(CP_TAG_CANCEL + t_cp'($urandom_range(1, 3)));
                            default: push_decode(t_cp'($urandom_range(CP_TAG_LO, CP_TAG_HI)));
                        endcase
                    end
                    if ($urandom_range(0, 3) != 0) push_decode(CP_TAG_CANCEL);
                end
                MODE_ZW: begin
                    if ($urandom_range(0, 5) == 0) begin
                        push_decode($urandom_range(0, 1) ? t_cp'(CP_ZWSP - 1)
                                                         : t_cp'(CP_ZWNJ + 1));
                    end else begin
                        push_decode($urandom_range(0, 1) ? CP_ZWNJ : CP_ZWSP);
                    end
                end
                MODE_NIBBLES: begin
                    if ($urandom_range(0, 5) == 0) begin
                        push_decode($urandom_range(0, 1) ? t_cp'(CP_VS_LO - 1)
                                                         : t_cp'(CP_VS_HI + 1));
                    end else begin
                        push_decode(CP_VS_LO + t_cp'($urandom_range(0, 15)));
                    end
                end
                MODE_MONGOLIAN: begin
                    case ($urandom_range(0, 5))
                        0: push_decode($urandom_range(0, 1) ? CP_FVS1 : CP_FVS2);
                        1: begin
                            push_decode(CP_MONGOLIAN_A);
                            push_decode(x);
                            push_decode(CP_FVS1);
                        end
                        2: begin
                            push_decode(CP_MONGOLIAN_A);
                            push_decode(CP_MONGOLIAN_A);
                            push_decode(CP_FVS2);
                        end
                        default: begin
                            push_decode(CP_MONGOLIAN_A);
                            push_decode($urandom_range(0, 1) ? CP_FVS1 : CP_FVS2);
                        end
                    endcase
                end
                MODE_BIDI: begin
                    if ($urandom_range(0, 5) == 0) begin
                        push_decode($urandom_range(0, 1) ? t_cp'(CP_LRI - 1)
                                                         : t_cp'(CP_RLI + 1));
                    end else begin
                        push_decode($urandom_range(0, 1) ? CP_RLI : CP_LRI);
                    end
                end
                MODE_MAP: begin
                    case ($urandom_range(0, 9))
                        0:       push_random_load();
                        1:       push_decode(x);
                        default: push_decode(gen_slot_cp[t_eidx'($urandom_range(0, MAP_DEPTH - 1))]);
                    endcase
                end
                MODE_PAIRS: begin
                    case ($urandom_range(0, 4))
                        0: begin
                            push_decode(x);
                            push_decode(x);
                        end
                        1: begin
                            push_decode(x);
                            push_decode(CP_ITER_MARK);
                        end
                        2: begin
                            push_decode(x);
                            push_decode(rand_cp());
                        end
                        3: push_decode(CP_IDEO_COMMA);
                        default: begin
                            push_decode(x);
                            push_decode(CP_IDEO_COMMA);
                            push_decode(x);
                            push_decode(x);
                        end
                    endcase
                end
                default: push_decode(x);
            endcase
        end
    endtask

    task automatic apply_config(input logic [2:0] mode, input logic lsb,
                                input logic [3:0] width, input logic [4:0] entries);
        begin
            @(negedge i_clk);
            cfg_we    <= 1'b1;
            cfg_idx   <= REG_DECODE_MODE;
            cfg_wdata <= CFG_DATA_W'(mode);
            @(negedge i_clk);
            cfg_idx   <= REG_LSB_FIRST;
            cfg_wdata <= CFG_DATA_W'(lsb);
            @(negedge i_clk);
            cfg_idx   <= REG_MAP_BIT_WIDTH;
            cfg_wdata <= CFG_DATA_W'(width);
            @(negedge i_clk);
            cfg_idx   <= REG_MAP_ENTRIES;
            cfg_wdata <= CFG_DATA_W'(entries);
            @(negedge i_clk);
            cfg_we    <= 1'b0;
            cfg_mode      = mode;
            cfg_lsb_first = lsb;
            cfg_width     = width;
            cfg_entries   = entries;
        end
    endtask

    // Load items give no result, so the pipeline is given time to empty after
    // the last expected transfer.
    task automatic settle();
        begin
            while (item_q.size() != 0 || bits_q.size() != 0) @(posedge i_clk);
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end
    endtask

    // Item driver.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_fired) begin
        end else if (in_gap != 0) begin
            in_ch.valid <= 1'b0;
            in_gap      <= in_gap - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 1'b0;
            in_gap      <= $urandom_range(0, 16);
        end else if (item_q.size() != 0) begin
            in_ch.valid           <= 1'b1;
            in_ch.opcode          <= item_q[0].opcode;
            in_ch.code_point      <= item_q[0].cp;
            in_ch.entry_index     <= item_q[0].idx;
            in_ch.entry_codepoint <= item_q[0].ecp;
            in_ch.entry_value     <= item_q[0].eval;
        end else begin
            in_ch.valid <= 1'b0;
        end
        in_fired = 1'b0;
    end

    // Receiver stalls.
    always @(negedge i_clk) begin
        if (out_stall != 0) begin
            out_ch.ready <= 1'b0;
            out_stall    <= out_stall - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            out_ch.ready <= 1'b0;
            out_stall    <= $urandom_range(0, 16);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Monitor: checks each output transfer, then predicts from each input transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (bits_q.size() == 0) begin
                    $error("unexpected result: out_bits %0h bit_count %0d",
                           out_ch.out_bits, out_ch.bit_count);
                    n_err++;
                end else begin
                    want = bits_q.pop_front();
                    if (out_ch.out_bits !== want.bits) begin
                        $error("out_bits: expected %0h, actual %0h", want.bits, out_ch.out_bits);
                        n_err++;
                    end
                    if (out_ch.bit_count !== want.cnt) begin
                        $error("bit_count: expected %0d, actual %0d",
                               want.cnt, out_ch.bit_count);
                        n_err++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                taken_item.opcode = in_ch.opcode;
                taken_item.cp     = in_ch.code_point;
                taken_item.idx    = in_ch.entry_index;
                taken_item.ecp    = in_ch.entry_codepoint;
                taken_item.eval   = in_ch.entry_value;
                extract_hidden_bits(taken_item);
                if (item_q.size() != 0) void'(item_q.pop_front());
                in_fired = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        logic [2:0]  mode;
        logic        lsb;
        logic [3:0]  width;
        logic [4:0]  entries;
        int unsigned map_k;
        int unsigned first;

        i_rst_n               = 1'b0;
        cfg_we                = 1'b0;
        cfg_idx               = '0;
        cfg_wdata             = '0;
        in_ch.valid           = 1'b0;
        in_ch.opcode          = OP_DECODE;
        in_ch.code_point      = '0;
        in_ch.entry_index     = '0;
        in_ch.entry_codepoint = '0;
        in_ch.entry_value     = '0;
        out_ch.ready          = 1'b0;
        cfg_mode              = MODE_TAGS;
        cfg_lsb_first         = 1'b0;
        cfg_width             = 4'd8;
        cfg_entries           = 5'd1;
        tag_run               = 1'b0;
        prev_mongolian_a      = 1'b0;
        pair_cp               = '0;
        pair_open             = 1'b0;
        gen_count             = 0;
        n_err                 = 0;
        cycles                = 0;
        in_gap                = 0;
        out_stall             = 0;
        in_fired              = 1'b0;
        idle_on               = 1'b1;
        map_k                 = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Every alphabet slot is loaded before any map lookup can reach it.
        for (int s = 0; s < MAP_DEPTH; s++) begin
            if (s == 0) push_load(t_eidx'(s), '0, 8'h00);
            else if (s == MAP_DEPTH - 1) push_load(t_eidx'(s), CP_MAX, 8'hFF);
            else if (s == 9) push_load(t_eidx'(s), gen_slot_cp[3], t_byte'($urandom));
            else push_load(t_eidx'(s), rand_cp(), t_byte'($urandom));
        end

        // Tag runs under the reset settings, with the code point extremes.
        push_decode(CP_MONGOLIAN_A);
        push_decode(CP_TAG_BEGIN);
        push_decode(CP_TAG_LO);
        push_decode(CP_TAG_HI);
        push_decode(t_cp'(CP_TAG_LO - 1));
        push_decode(CP_TAG_CANCEL);
        push_decode(CP_TAG_LO + 21'h21);
        push_decode('0);
        push_decode(CP_MAX);
        push_decode(CP_TAG_BEGIN);
        settle();

        for (int p = 0; p < N_PHASES; p++) begin
            if (p < 16) mode = 3'(p);
            else if (p % 2 == 1) mode = MODE_MAP;
            else mode = 3'($urandom_range(0, 7));
            lsb     = 1'($urandom_range(0, 1));
            width   = 4'($urandom_range(0, 15));
            entries = 5'($urandom_range(0, 31));
            if (mode == MODE_MAP) begin
                case (map_k)
                    0: {width, entries, lsb} = {4'd8, 5'd16, 1'b0};
                    1: {width, entries, lsb} = {4'd1, 5'd1, 1'b1};
                    2: {width, entries, lsb} = {4'd0, 5'd0, 1'b0};
                    3: {width, entries, lsb} = {4'd15, 5'd31, 1'b1};
                    4: {width, entries, lsb} = {4'd8, 5'd17, 1'b1};
                    5: {width, entries, lsb} = {4'd4, 5'd16, 1'b0};
                    6: {width, entries, lsb} = {4'd9, 5'd5, 1'b0};
                    7: {width, entries, lsb} = {4'd2, 5'd16, 1'b1};
                    default: begin
                    end
                endcase
                map_k++;
            end
            idle_on = (p < N_PHASES - CALM_PHASES) && ($urandom_range(0, 3) != 0);
            apply_config(mode, lsb, width, entries);
            first = gen_count;
            while (gen_count - first < PHASE_ITEMS) begin
                if ($urandom_range(0, 5) == 0) push_decode(rand_cp());
                else if ($urandom_range(0, 19) == 0) push_random_load();
                else push_burst(mode);
            end
            settle();
        end

        if (n_err == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
